/* sv/cosrs_pkg.sv */
package cosrs_pkg;

   // Command codes
   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_END  = 2'd1;
   localparam logic [1:0] OP_SORT = 2'd2;
   localparam logic [1:0] OP_READ = 2'd3;

   // Result status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_UNKNOWN = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;
   localparam logic [1:0] ST_RANGE   = 2'd3;

   // Register indexes
   localparam logic [1:0] CSR_LOW  = 2'd0;
   localparam logic [1:0] CSR_MID  = 2'd1;
   localparam logic [1:0] CSR_HIGH = 2'd2;
   localparam logic [1:0] CSR_TOP  = 2'd3;

   // Character constants
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   // Order table: 26 ranked characters
   localparam int ORDER_RANKS = 26;
   localparam int ORDER_BITS  = ORDER_RANKS * 8;

   typedef logic [7:0] char_type;

   // Classifier result: class number and unknown-character flag
   typedef struct packed {
      logic       unknown;
      logic [5:0] cls;
   } class_res_type;

endpackage

/* sv/cosrs_ram.sv */
module cosrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

/* sv/cosrs_class.sv */
module cosrs_class import cosrs_pkg::*; #(
   parameter int NUM_CLASSES = 27
) (
   input  logic [ORDER_BITS-1:0] order_chars,
   input  char_type              char_in,
   output class_res_type         result
);

   localparam int LIMIT = (NUM_CLASSES - 1 > ORDER_RANKS) ? ORDER_RANKS : NUM_CLASSES - 1;

   // Compare against every rank at once; the lowest matching rank wins
   always_comb begin
      result.unknown = 1'b0;
      result.cls     = '0;
      for (int r = LIMIT; r >= 1; r--) begin
         if (order_chars[(r-1)*8 +: 8] == char_in) begin
            result.cls = 6'(r);
         end
      end
      if (char_in == CHAR_SPACE) begin
         result.cls = '0;
      end else if (result.cls == '0) begin
         result.unknown = 1'b1;
      end
   end

endmodule

/* sv/custom_order_string_radix_sort.sv */
// Custom-order string radix sort. Load and end-of-string commands leave busy low. A read
// command gives its result through an order lookup, a string lookup and then the result
// register; a read past the sorted count gives status 3 on the next cycle. A sort holds busy
// while it runs: it fills order_a in load order, then for each character position, from the
// last, runs a clear step, a count sweep over the strings through the string store, a prefix
// sweep over the classes, a place sweep back through the strings and a copy sweep from
// order_b back to order_a. Every result is shown for exactly one cycle with rsp_valid high
// and cannot be held off; busy is low in that cycle.
module custom_order_string_radix_sort import cosrs_pkg::*; #(
   parameter int MAX_STRINGS = 256,
   parameter int MAX_LEN     = 16,
   parameter int NUM_CLASSES = 27
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_char_in,
   input  logic [7:0]  req_read_rank,
   input  logic [3:0]  req_read_pos,
   output logic        rsp_valid,
   output logic [7:0]  rsp_char_out,
   output logic [7:0]  rsp_source_index,
   output logic [4:0]  rsp_max_length,
   output logic [1:0]  rsp_status,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   localparam int AW  = $clog2(MAX_STRINGS);
   localparam int CW  = $clog2(MAX_STRINGS + 1);
   localparam int LW  = $clog2(MAX_LEN + 1);
   localparam int KW  = (NUM_CLASSES > 2) ? $clog2(NUM_CLASSES) : 1;
   localparam int SD  = MAX_STRINGS * MAX_LEN;
   localparam int SAW = $clog2(SD);

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_INIT = 5'd1;
   localparam logic [4:0] S_CLR  = 5'd2;
   localparam logic [4:0] S_A    = 5'd3;
   localparam logic [4:0] S_B    = 5'd4;
   localparam logic [4:0] S_C    = 5'd5;
   localparam logic [4:0] S_PFX  = 5'd6;
   localparam logic [4:0] S_YA   = 5'd7;
   localparam logic [4:0] S_YB   = 5'd8;
   localparam logic [4:0] S_RA   = 5'd9;
   localparam logic [4:0] S_RB   = 5'd10;
   localparam logic [4:0] S_RC   = 5'd11;
   localparam logic [4:0] S_DONE = 5'd12;

   logic [4:0]      state_ff, state_in;
   logic [AW-1:0]   idx_ff, idx_in;
   logic [CW-1:0]   n_ff, n_in;
   logic [CW-1:0]   sorted_n_ff, sorted_n_in;
   logic [LW-1:0]   pos_ff, pos_in;
   logic [KW-1:0]   k_ff, k_in;
   logic [CW-1:0]   acc_ff, acc_in;
   logic            placing_ff, placing_in;
   logic [AW-1:0]   e_ff, e_in;
   logic [7:0]      rank_ff, rank_in;
   logic [3:0]      rpos_ff, rpos_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [LW-1:0]   charpos_ff, charpos_in;
   logic [LW-1:0]   longest_ff, longest_in;
   logic            err_unk_ff, err_unk_in;
   logic            err_ovf_ff, err_ovf_in;
   logic [63:0]     ord_low_ff, ord_mid_ff, ord_high_ff;
   logic [15:0]     ord_top_ff;
   logic [CW-1:0]   counts_ff [NUM_CLASSES];
   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      rsp_char_ff, rsp_char_in;
   logic [7:0]      rsp_idx_ff, rsp_idx_in;
   logic [1:0]      rsp_status_ff, rsp_status_in;

   logic            counts_clr, counts_we;
   logic [KW-1:0]   counts_wk;
   logic [CW-1:0]   counts_wd;
   logic [KW-1:0]   k_sel;
   logic [CW-1:0]   cnt_rd;

   logic            st_we, len_we, oa_we, ob_we;
   logic [SAW-1:0]  st_waddr, st_raddr;
   logic [7:0]      st_wdata, st_rd;
   logic [LW-1:0]   len_rd;
   logic [AW-1:0]   oa_waddr, oa_wdata, oa_raddr, oa_rd;
   logic [AW-1:0]   ob_waddr, ob_rd;
   logic [AW-1:0]   e_lookup;
   logic [LW-1:0]   p_cur;
   logic [AW-1:0]   last_idx;
   logic [7:0]      load_char;
   char_type        sort_char;
   class_res_type   cres;
   logic [KW-1:0]   cls;
   logic [CW-1:0]   cnt_dec;

   // Shared memories
   cosrs_ram #(.WIDTH(8), .DEPTH(SD)) u_store (
      .clock(clock), .wr_en(st_we), .wr_addr(st_waddr), .wr_data(st_wdata),
      .rd_addr(st_raddr), .rd_data(st_rd)
   );
   cosrs_ram #(.WIDTH(LW), .DEPTH(MAX_STRINGS)) u_lengths (
      .clock(clock), .wr_en(len_we), .wr_addr(count_ff[AW-1:0]), .wr_data(charpos_ff),
      .rd_addr(e_lookup), .rd_data(len_rd)
   );
   cosrs_ram #(.WIDTH(AW), .DEPTH(MAX_STRINGS)) u_order_a (
      .clock(clock), .wr_en(oa_we), .wr_addr(oa_waddr), .wr_data(oa_wdata),
      .rd_addr(oa_raddr), .rd_data(oa_rd)
   );
   cosrs_ram #(.WIDTH(AW), .DEPTH(MAX_STRINGS)) u_order_b (
      .clock(clock), .wr_en(ob_we), .wr_addr(ob_waddr), .wr_data(e_ff),
      .rd_addr(idx_ff), .rd_data(ob_rd)
   );

   // Shared classifier
   cosrs_class #(.NUM_CLASSES(NUM_CLASSES)) u_class (
      .order_chars({ord_top_ff, ord_high_ff, ord_mid_ff, ord_low_ff}),
      .char_in(sort_char),
      .result(cres)
   );

   // Address and operand paths
   always_comb begin
      p_cur     = pos_ff - LW'(1);
      last_idx  = AW'(n_ff - CW'(1));
      e_lookup  = oa_rd;
      oa_raddr  = (state_ff == S_RA) ? AW'(rank_ff) : idx_ff;
      if (state_ff == S_RB) begin
         st_raddr = SAW'(oa_rd) * SAW'(MAX_LEN) + SAW'(rpos_ff);
      end else begin
         st_raddr = SAW'(oa_rd) * SAW'(MAX_LEN) + SAW'(p_cur);
      end
      st_waddr  = SAW'(count_ff) * SAW'(MAX_LEN) + SAW'(charpos_ff);
      load_char = req_char_in;
      if (req_char_in >= CHAR_UPPER_A && req_char_in <= CHAR_UPPER_Z) begin
         load_char = req_char_in + CASE_OFFSET;
      end
      st_wdata  = load_char;
      sort_char = (p_cur < len_rd) ? st_rd : CHAR_SPACE;
      cls       = KW'(cres.cls);
      k_sel     = (state_ff == S_PFX) ? k_ff : cls;
      cnt_rd    = counts_ff[k_sel];
      cnt_dec   = cnt_rd - CW'(1);
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      n_in          = n_ff;
      sorted_n_in   = sorted_n_ff;
      pos_in        = pos_ff;
      k_in          = k_ff;
      acc_in        = acc_ff;
      placing_in    = placing_ff;
      e_in          = e_ff;
      rank_in       = rank_ff;
      rpos_in       = rpos_ff;
      count_in      = count_ff;
      charpos_in    = charpos_ff;
      longest_in    = longest_ff;
      err_unk_in    = err_unk_ff;
      err_ovf_in    = err_ovf_ff;
      rsp_valid_in  = 1'b0;
      rsp_char_in   = rsp_char_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_status_in = rsp_status_ff;
      counts_clr    = 1'b0;
      counts_we     = 1'b0;
      counts_wk     = k_sel;
      counts_wd     = cnt_rd;
      st_we         = 1'b0;
      len_we        = 1'b0;
      oa_we         = 1'b0;
      oa_waddr      = idx_ff;
      oa_wdata      = idx_ff;
      ob_we         = 1'b0;
      ob_waddr      = AW'(cnt_dec);
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (req_opcode)
                  OP_LOAD: begin
                     if (count_ff >= CW'(MAX_STRINGS) || charpos_ff >= LW'(MAX_LEN)) begin
                        err_ovf_in = 1'b1;
                     end else begin
                        st_we      = 1'b1;
                        charpos_in = charpos_ff + LW'(1);
                     end
                  end
                  OP_END: begin
                     if (count_ff >= CW'(MAX_STRINGS)) begin
                        err_ovf_in = 1'b1;
                     end else begin
                        len_we   = 1'b1;
                        count_in = count_ff + CW'(1);
                        if (charpos_ff > longest_ff) begin
                           longest_in = charpos_ff;
                        end
                     end
                     charpos_in = '0;
                  end
                  OP_SORT: begin
                     err_unk_in  = 1'b0;
                     n_in        = count_ff;
                     sorted_n_in = count_ff;
                     idx_in      = '0;
                     state_in    = (count_ff == '0) ? S_DONE : S_INIT;
                  end
                  OP_READ: begin
                     if (32'(req_read_rank) >= 32'(sorted_n_ff)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_char_in   = '0;
                        rsp_idx_in    = '0;
                        rsp_status_in = ST_RANGE;
                     end else begin
                        rank_in  = req_read_rank;
                        rpos_in  = req_read_pos;
                        state_in = S_RA;
                     end
                  end
               endcase
            end
         end
         // Fill order_a with load order
         S_INIT: begin
            oa_we  = 1'b1;
            idx_in = idx_ff + AW'(1);
            if (idx_ff == last_idx) begin
               if (longest_ff == '0) begin
                  state_in = S_DONE;
               end else begin
                  pos_in   = longest_ff;
                  state_in = S_CLR;
               end
            end
         end
         S_CLR: begin
            counts_clr = 1'b1;
            idx_in     = '0;
            placing_in = 1'b0;
            state_in   = S_A;
         end
         S_A: state_in = S_B;
         S_B: begin
            e_in     = oa_rd;
            state_in = S_C;
         end
         // Classify one entry: count it, or place it backwards
         S_C: begin
            counts_we = 1'b1;
            if (cres.unknown) begin
               err_unk_in = 1'b1;
            end
            if (!placing_ff) begin
               counts_wd = cnt_rd + CW'(1);
               if (idx_ff == last_idx) begin
                  k_in     = '0;
                  acc_in   = '0;
                  state_in = S_PFX;
               end else begin
                  idx_in   = idx_ff + AW'(1);
                  state_in = S_A;
               end
            end else begin
               counts_wd = cnt_dec;
               ob_we     = 1'b1;
               if (idx_ff == '0) begin
                  state_in = S_YA;
               end else begin
                  idx_in   = idx_ff - AW'(1);
                  state_in = S_A;
               end
            end
         end
         // Running prefix sum, one class a cycle
         S_PFX: begin
            counts_we = 1'b1;
            counts_wd = acc_ff + cnt_rd;
            acc_in    = acc_ff + cnt_rd;
            k_in      = k_ff + KW'(1);
            if (k_ff == KW'(NUM_CLASSES - 1)) begin
               idx_in     = last_idx;
               placing_in = 1'b1;
               state_in   = S_A;
            end
         end
         S_YA: state_in = S_YB;
         // Copy order_b back to order_a
         S_YB: begin
            oa_we    = 1'b1;
            oa_wdata = ob_rd;
            idx_in   = idx_ff + AW'(1);
            state_in = S_YA;
            if (idx_ff == last_idx) begin
               if (pos_ff == LW'(1)) begin
                  state_in = S_DONE;
               end else begin
                  pos_in   = pos_ff - LW'(1);
                  state_in = S_CLR;
               end
            end
         end
         S_RA: state_in = S_RB;
         S_RB: begin
            e_in     = oa_rd;
            state_in = S_RC;
         end
         S_RC: begin
            rsp_valid_in  = 1'b1;
            rsp_idx_in    = 8'(e_ff);
            rsp_status_in = ST_OK;
            if (32'(rpos_ff) < MAX_LEN && 32'(rpos_ff) < 32'(len_rd)) begin
               rsp_char_in = st_rd;
            end else begin
               rsp_char_in = CHAR_SPACE;
            end
            state_in = S_IDLE;
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = '0;
            rsp_idx_in   = '0;
            if (err_ovf_ff) begin
               rsp_status_in = ST_OVERFLOW;
            end else if (err_unk_ff) begin
               rsp_status_in = ST_UNKNOWN;
            end else begin
               rsp_status_in = ST_OK;
            end
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         charpos_ff   <= '0;
         longest_ff   <= '0;
         sorted_n_ff  <= '0;
         err_unk_ff   <= 1'b0;
         err_ovf_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ord_low_ff   <= '0;
         ord_mid_ff   <= '0;
         ord_high_ff  <= '0;
         ord_top_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         charpos_ff   <= charpos_in;
         longest_ff   <= longest_in;
         sorted_n_ff  <= sorted_n_in;
         err_unk_ff   <= err_unk_in;
         err_ovf_ff   <= err_ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_LOW:  ord_low_ff  <= csr_wdata;
               CSR_MID:  ord_mid_ff  <= csr_wdata;
               CSR_HIGH: ord_high_ff <= csr_wdata;
               CSR_TOP:  ord_top_ff  <= csr_wdata[15:0];
            endcase
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      n_ff          <= n_in;
      pos_ff        <= pos_in;
      k_ff          <= k_in;
      acc_ff        <= acc_in;
      placing_ff    <= placing_in;
      e_ff          <= e_in;
      rank_ff       <= rank_in;
      rpos_ff       <= rpos_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_status_ff <= rsp_status_in;
      if (counts_clr) begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            counts_ff[c] <= '0;
         end
      end else if (counts_we) begin
         counts_ff[counts_wk] <= counts_wd;
      end
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_char_out     = rsp_char_ff;
   assign rsp_source_index = rsp_idx_ff;
   assign rsp_max_length   = 5'(longest_ff);
   assign rsp_status       = rsp_status_ff;

endmodule

/* sv/cosrs_checker.sv */
module cosrs_checker import cosrs_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [1:0]  req_opcode,
   input logic        rsp_valid,
   input logic [7:0]  rsp_char_out,
   input logic [7:0]  rsp_source_index,
   input logic [1:0]  rsp_status
);

   // A result never appears while a command is in work
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");

   // Load and end give no result and leave the block ready
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_opcode == OP_LOAD || req_opcode == OP_END))
      |=> (!rsp_valid && !busy)) else $error("load or end misbehaved");

   // A sort or read keeps the block busy or answers next cycle
   a_cmd_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_opcode == OP_SORT || req_opcode == OP_READ))
      |=> (busy || rsp_valid)) else $error("command dropped");

   // Out-of-range reads carry zero payload
   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_RANGE) |-> (rsp_char_out == '0 && rsp_source_index == '0))
      else $error("range result payload nonzero");

endmodule

bind custom_order_string_radix_sort cosrs_checker u_cosrs_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .req_opcode(req_opcode),
   .rsp_valid(rsp_valid), .rsp_char_out(rsp_char_out), .rsp_source_index(rsp_source_index),
   .rsp_status(rsp_status)
);
